// ===== design/hsl_pkg.sv =====
// Shared constants, types and the hue weight function for the HSL saturation scaler.
`timescale 1ns / 1ps
`default_nettype none
package hsl_pkg;

	// pipeline depth of each divider
	localparam int DIV_STAGES = 5;

	// hue is held in 1/64 degree units
	localparam logic signed [16:0] HUE_FULL       = 17'sd23040;
	localparam logic signed [16:0] HUE_THIRD      = 17'sd7680;
	localparam logic signed [16:0] HUE_SIXTH      = 17'sd3840;
	localparam logic signed [16:0] HUE_HALF       = 17'sd11520;
	localparam logic signed [16:0] HUE_TWO_THIRDS = 17'sd15360;

	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [16:0] HALF_Q16 = 17'd32768;

	// ceil(2^19 / 15), exact quotient by 15 for values below 2^16
	localparam logic [15:0] RECIP_15 = 16'd34953;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// ramp weight on [0, 3840] for one channel, hue already offset
	function automatic logic [11:0] hue_weight(input logic signed [16:0] t_in);
		logic signed [16:0] t;
		logic [11:0] w;
		t = t_in;
		if (t < 0)
			t = t + HUE_FULL;
		else if (t > HUE_FULL)
			t = t - HUE_FULL;
		priority if (t < HUE_SIXTH) begin
			w = 12'(t);
		end else if (t < HUE_HALF) begin
			w = 12'(HUE_SIXTH);
		end else if (t < HUE_TWO_THIRDS) begin
			w = 12'(HUE_TWO_THIRDS - t);
		end else begin
			w = 12'd0;
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== design/hsl_div_pipe.sv =====
// Pipelined restoring divider, a few quotient bits per stage, with a payload lane.
`timescale 1ns / 1ps
`default_nettype none
module hsl_div_pipe
	import hsl_pkg::*;
#(
	parameter int QW = 12,
	parameter int DW = 9,
	parameter int PW = 1
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] num_hi,   // dividend >> QW, below divisor
	input  wire logic [QW-1:0] num_lo,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [PW-1:0] pay_in,
	output logic      [QW-1:0] quo,
	output logic      [PW-1:0] pay_out
);

	localparam int SPS = (QW + DIV_STAGES - 1) / DIV_STAGES;

	logic [DW-1:0] rem_s [DIV_STAGES-1];
	logic [QW-1:0] lo_s  [DIV_STAGES-1];
	logic [DW-1:0] div_s [DIV_STAGES-1];
	logic [QW-1:0] quo_s [DIV_STAGES];
	logic [PW-1:0] pay_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DW-1:0] rem_i, dv_i, rem_n;
		logic [QW-1:0] lo_i, quo_i, lo_n, quo_n;
		logic [PW-1:0] pay_i;

		if (g == 0) begin : g_first
			assign rem_i = num_hi;
			assign lo_i  = num_lo;
			assign dv_i  = divisor;
			assign quo_i = '0;
			assign pay_i = pay_in;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign lo_i  = lo_s[g-1];
			assign dv_i  = div_s[g-1];
			assign quo_i = quo_s[g-1];
			assign pay_i = pay_s[g-1];
		end

		always_comb begin : steps
			logic [DW:0] tr;
			rem_n = rem_i;
			lo_n  = lo_i;
			quo_n = quo_i;
			tr    = '0;
			for (int j = 0; j < SPS; j++) begin
				if (g * SPS + j < QW) begin
					tr = {rem_n, lo_n[QW-1]};
					if (tr >= {1'b0, dv_i}) begin
						tr    = tr - {1'b0, dv_i};
						quo_n = {quo_n[QW-2:0], 1'b1};
					end else begin
						quo_n = {quo_n[QW-2:0], 1'b0};
					end
					rem_n = tr[DW-1:0];
					lo_n  = {lo_n[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[g] <= quo_n;
				pay_s[g] <= pay_i;
			end
		end

		if (g < DIV_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= rem_n;
					lo_s[g]  <= lo_n;
					div_s[g] <= dv_i;
				end
			end
		end
	end

	assign quo     = quo_s[DIV_STAGES-1];
	assign pay_out = pay_s[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== design/hsl_chan.sv =====
// Three-stage back end for one color channel: ramp value, scale to full range, divide by 15 and clamp.
`timescale 1ns / 1ps
`default_nettype none
module hsl_chan
	import hsl_pkg::*;
#(
	parameter int CB = 8
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [17:0]   p,
	input  wire logic [17:0]   qp,      // q - p
	input  wire logic [11:0]   w,
	output logic      [CB-1:0] val
);

	localparam logic [CB-1:0] MAXV = CB'((1 << CB) - 1);

	logic [29:0]    x_s1;
	logic [16:0]    z_s2;
	logic [CB-1:0]  v_s3;

	logic [29:0]    x_n;
	logic [29+CB:0] y_n;
	logic [32:0]    zr_n;
	logic [13:0]    v_n;

	// X = p*3840 + (q-p)*w
	assign x_n = (30'(p) << 12) - (30'(p) << 8) + 30'(qp) * 30'(w);

	// Z = floor(X*M / 2^24), then divide by 15
	assign y_n  = (30+CB)'(x_s1) * (30+CB)'(MAXV);
	assign zr_n = 33'(z_s2) * 33'(RECIP_15);
	assign v_n  = zr_n[19 +: 14];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_n;
			z_s2 <= 17'(y_n[29+CB:24]);
			v_s3 <= (v_n > 14'(MAXV)) ? MAXV : v_n[CB-1:0];
		end
	end

	assign val = v_s3;

endmodule
`default_nettype wire

// ===== design/hsl_saturation_scaler_top.sv =====
// Top level of the HSL saturation scaler: stream ports, front end, dividers and HSL math.
`timescale 1ns / 1ps
`default_nettype none
// One RGBA pixel enters per clock and one leaves per clock unless the output
// stalls; each pixel passes through the input register, min/max front end,
// a five-stage divider pair for hue and saturation, four HSL stages and
// three channel stages. The whole pipeline advances on one enable, high whenever
// the output register is empty or being taken, so s_tready drops only while
// a result waits at the output; no pixel is lost or repeated across a stall.
// saturation_gain is signed Q.12 and scales saturation by (1 + gain); write it
// through cfg_valid/cfg_data only while no pixel is in flight. Alpha and
// tlast pass through untouched.
module hsl_saturation_scaler_top
	import hsl_pkg::*;
#(
	parameter int COLOR_BITS = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic signed [14:0]                     cfg_data,  // saturation_gain
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// red_in, green_in, blue_in, alpha_in from bit 0 up, zero padded
	input  wire logic [((3*COLOR_BITS+15)/8)*8-1:0]     s_tdata,
	input  wire logic                                   s_tlast,   // frame_end_in
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// red_out, green_out, blue_out, alpha_out from bit 0 up, zero padded
	output logic      [((3*COLOR_BITS+15)/8)*8-1:0]     m_tdata,
	output logic                                        m_tlast    // frame_end_out
);

	localparam int CB   = COLOR_BITS;
	localparam int TDW  = ((3*CB+15)/8)*8;
	localparam int LAT  = 14;
	localparam int HNW  = CB + 13;          // hue dividend width
	localparam int XW   = CB + 16;          // lightness dividend width
	localparam int XRW  = XW + 30;
	localparam logic [CB-1:0] MAXV = CB'((1 << CB) - 1);
	// floor(2^29 / M): quotient estimate low by at most one
	localparam logic [29:0] LQ_RECIP = 30'((64'd1 << 29) / ((64'd1 << CB) - 64'd1));
	localparam int SPW  = CB + 11;          // saturation divider payload

	// valid bit of each stage, index = stage - 1
	logic [LAT-1:0] vld_q;
	logic           en;
	logic signed [14:0] gain_q;

	assign en        = !vld_q[LAT-1] || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			vld_q  <= '0;
		end else begin
			if (cfg_valid)
				gain_q <= cfg_data;
			if (en)
				vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// ---- stage 1: input register
	logic [CB-1:0] r_s1, g_s1, b_s1;
	logic [7:0]    al_s1;
	logic          last_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= s_tdata[0 +: CB];
			g_s1    <= s_tdata[CB +: CB];
			b_s1    <= s_tdata[2*CB +: CB];
			al_s1   <= s_tdata[3*CB +: 8];
			last_s1 <= s_tlast;
		end
	end

	// ---- stage 2: max/min, hue sector, divider operands
	logic [CB-1:0] mx, mn, d_n, num_n, den_n;
	logic [CB:0]   sum_n;
	logic          neg_n;
	sector_t       sect_n;
	logic [HNW-1:0] hnum_n;

	always_comb begin
		mx = r_s1;
		mn = r_s1;
		if (g_s1 > mx) mx = g_s1;
		if (b_s1 > mx) mx = b_s1;
		if (g_s1 < mn) mn = g_s1;
		if (b_s1 < mn) mn = b_s1;
		d_n   = mx - mn;
		sum_n = {1'b0, mx} + {1'b0, mn};
		// first channel equal to max wins, red before green
		priority if (mx == r_s1) begin
			sect_n = SECT_RED;
			neg_n  = g_s1 < b_s1;
			num_n  = neg_n ? b_s1 - g_s1 : g_s1 - b_s1;
		end else if (mx == g_s1) begin
			sect_n = SECT_GREEN;
			neg_n  = b_s1 < r_s1;
			num_n  = neg_n ? r_s1 - b_s1 : b_s1 - r_s1;
		end else begin
			sect_n = SECT_BLUE;
			neg_n  = r_s1 < g_s1;
			num_n  = neg_n ? g_s1 - r_s1 : r_s1 - g_s1;
		end
		den_n  = (sum_n <= {1'b0, MAXV}) ? sum_n[CB-1:0]
			: CB'(({1'b0, MAXV} << 1) - sum_n);
		// 7680*num + d, rounding term for the hue quotient
		hnum_n = (HNW'(num_n) << 13) - (HNW'(num_n) << 9) + HNW'(d_n);
	end

	logic [HNW-1:0] hnum_s2;
	logic [CB-1:0]  d_s2, den_s2;
	logic [CB:0]    sum_s2;
	logic           neg_s2, gz_s2, last_s2;
	sector_t        sect_s2;
	logic [7:0]     al_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			hnum_s2 <= hnum_n;
			d_s2    <= d_n;
			den_s2  <= den_n;
			sum_s2  <= sum_n;
			neg_s2  <= neg_n;
			sect_s2 <= sect_n;
			gz_s2   <= (d_n == '0);
			al_s2   <= al_s1;
			last_s2 <= last_s1;
		end
	end

	// ---- stages 3..7: hue magnitude and saturation quotients
	logic [11:0]    mag_s7;
	logic [2:0]     hpay_s7;
	logic [16:0]    sq_s7;
	logic [SPW-1:0] spay_s7;

	hsl_div_pipe #(
		.QW (12),
		.DW (CB + 1),
		.PW (3)
	) u_hue_div (
		.clk     (clk),
		.en      (en),
		.num_hi  (hnum_s2[HNW-1:12]),
		.num_lo  (hnum_s2[11:0]),
		.divisor ({d_s2, 1'b0}),
		.pay_in  ({neg_s2, sect_s2}),
		.quo     (mag_s7),
		.pay_out (hpay_s7)
	);

	// 65536*d / den
	hsl_div_pipe #(
		.QW (17),
		.DW (CB),
		.PW (SPW)
	) u_sat_div (
		.clk     (clk),
		.en      (en),
		.num_hi  ({1'b0, d_s2[CB-1:1]}),
		.num_lo  ({d_s2[0], 16'd0}),
		.divisor (den_s2),
		.pay_in  ({gz_s2, sum_s2, al_s2, last_s2}),
		.quo     (sq_s7),
		.pay_out (spay_s7)
	);

	logic          neg_s7, gz_s7, last_s7;
	sector_t       sect_s7;
	logic [CB:0]   sum_s7;
	logic [7:0]    al_s7;

	assign neg_s7  = hpay_s7[2];
	assign sect_s7 = sector_t'(hpay_s7[1:0]);
	assign {gz_s7, sum_s7, al_s7, last_s7} = spay_s7;

	// ---- stage 8: hue, gain product, lightness estimate
	logic [14:0]        h_n;
	logic [16:0]        sq_eff;
	logic signed [15:0] fac;
	logic signed [33:0] prod_n;
	logic [XW-1:0]      x_n;
	logic [XRW-1:0]     xr_n;

	always_comb begin
		unique case (sect_s7)
			SECT_RED:   h_n = neg_s7 ? 15'(HUE_FULL) - 15'(mag_s7) : 15'(mag_s7);
			SECT_GREEN: h_n = neg_s7 ? 15'(HUE_THIRD) - 15'(mag_s7)
				: 15'(HUE_THIRD) + 15'(mag_s7);
			SECT_BLUE:  h_n = neg_s7 ? 15'(HUE_TWO_THIRDS) - 15'(mag_s7)
				: 15'(HUE_TWO_THIRDS) + 15'(mag_s7);
			default:    h_n = '0;
		endcase
	end

	assign sq_eff = gz_s7 ? '0 : sq_s7;
	assign fac    = 16'sd4096 + {gain_q[14], gain_q};
	assign prod_n = $signed({1'b0, sq_eff}) * fac;
	// sum*32768 + M - 1, so the floor below gives ceil(sum*32768/M)
	assign x_n    = (XW'(sum_s7) << 15) + XW'(MAXV) - XW'(1);
	assign xr_n   = XRW'(x_n) * XRW'(LQ_RECIP);

	logic [14:0]        h_s8;
	logic signed [33:0] prod_s8;
	logic [XW-1:0]      x_s8;
	logic [16:0]        q0_s8;
	logic [7:0]         al_s8;
	logic               last_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			h_s8    <= h_n;
			prod_s8 <= prod_n;
			x_s8    <= x_n;
			q0_s8   <= xr_n[29 +: 17];
			al_s8   <= al_s7;
			last_s8 <= last_s7;
		end
	end

	// ---- stage 9: scaled saturation, exact lightness, channel weights
	logic [16:0]        ss_n, lq_n;
	logic [XW-1:0]      rem_n;
	logic signed [16:0] hs;

	always_comb begin
		if (prod_s8 <= 0)
			ss_n = '0;
		else if (prod_s8[33:12] > 22'(ONE_Q16))
			ss_n = ONE_Q16;
		else
			ss_n = prod_s8[28:12];
		rem_n = x_s8 - XW'(q0_s8) * XW'(MAXV);
		lq_n  = (rem_n >= XW'(MAXV)) ? q0_s8 + 17'd1 : q0_s8;
	end

	assign hs = signed'({2'b00, h_s8});

	logic [16:0] ss_s9, lq_s9;
	logic [11:0] wr_s9, wg_s9, wb_s9;
	logic [7:0]  al_s9;
	logic        last_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s9   <= ss_n;
			lq_s9   <= lq_n;
			wr_s9   <= hue_weight(hs + HUE_THIRD);
			wg_s9   <= hue_weight(hs);
			wb_s9   <= hue_weight(hs - HUE_THIRD);
			al_s9   <= al_s8;
			last_s9 <= last_s8;
		end
	end

	// ---- stage 10: L*S
	logic [33:0] ls_n;
	assign ls_n = 34'(lq_s9) * 34'(ss_s9);

	logic [17:0] ls_s10;
	logic [16:0] ss_s10, lq_s10;
	logic [11:0] wr_s10, wg_s10, wb_s10;
	logic [7:0]  al_s10;
	logic        last_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			ls_s10   <= ls_n[33:16];
			ss_s10   <= ss_s9;
			lq_s10   <= lq_s9;
			wr_s10   <= wr_s9;
			wg_s10   <= wg_s9;
			wb_s10   <= wb_s9;
			al_s10   <= al_s9;
			last_s10 <= last_s9;
		end
	end

	// ---- stage 11: q and p
	logic [17:0] qv_n, pv_n;

	always_comb begin
		if (lq_s10 < HALF_Q16)
			qv_n = 18'(lq_s10) + ls_s10;
		else
			qv_n = 18'(lq_s10) + 18'(ss_s10) - ls_s10;
		pv_n = (18'(lq_s10) << 1) - qv_n;
	end

	logic [17:0] p_s11, qp_s11;
	logic [11:0] wr_s11, wg_s11, wb_s11;
	logic [7:0]  al_s11;
	logic        last_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s11    <= pv_n;
			qp_s11   <= qv_n - pv_n;
			wr_s11   <= wr_s10;
			wg_s11   <= wg_s10;
			wb_s11   <= wb_s10;
			al_s11   <= al_s10;
			last_s11 <= last_s10;
		end
	end

	// ---- stages 12..14: per-channel back end
	logic [CB-1:0] red_o, green_o, blue_o;

	hsl_chan #(.CB(CB)) u_chan_r (
		.clk (clk), .en (en), .p (p_s11), .qp (qp_s11), .w (wr_s11), .val (red_o)
	);
	hsl_chan #(.CB(CB)) u_chan_g (
		.clk (clk), .en (en), .p (p_s11), .qp (qp_s11), .w (wg_s11), .val (green_o)
	);
	hsl_chan #(.CB(CB)) u_chan_b (
		.clk (clk), .en (en), .p (p_s11), .qp (qp_s11), .w (wb_s11), .val (blue_o)
	);

	logic [7:0] al_s12, al_s13, al_s14;
	logic       last_s12, last_s13, last_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			al_s12   <= al_s11;
			al_s13   <= al_s12;
			al_s14   <= al_s13;
			last_s12 <= last_s11;
			last_s13 <= last_s12;
			last_s14 <= last_s13;
		end
	end

	assign m_tvalid = vld_q[LAT-1];
	assign m_tlast  = last_s14;
	assign m_tdata  = TDW'({al_s14, blue_o, green_o, red_o});

	// ---- checks
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(en && s_tvalid) |=> vld_q[0])
		else $error("accepted item did not enter stage 1");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valids moved during a stall");

	a_sl_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[8] |-> (lq_s9 <= ONE_Q16) && (ss_s9 <= ONE_Q16))
		else $error("lightness or scaled saturation above one");

	a_pq_sign: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[10] |-> !p_s11[17] && !qp_s11[17])
		else $error("p or q-p wrapped negative");

endmodule
`default_nettype wire
